@@ rtl/core/ssi_pkg.sv @@
package ssi_pkg;

    // Default store depth
    localparam int CAPACITY_DEF = 16;

    // Command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DUMP   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // Result status codes
    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_DUP      = 3'd1,
        ST_FULL     = 3'd2,
        ST_ENTRY    = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_WRITE,
        S_RESULT,
        S_DUMP_RD,
        S_DUMP_OUT
    } ssi_state_t;

    // Command word
    typedef struct packed {
        logic        [1:0]  cmd;
        logic signed [31:0] value;
    } ssi_req_t;

    // Result word
    typedef struct packed {
        logic        [2:0]  status;
        logic        [4:0]  position;
        logic signed [31:0] entry_value;
        logic        [4:0]  entry_count;
        logic               last;
    } ssi_rsp_t;

endpackage

@@ rtl/core/sorted_set_insert_top.sv @@
// Sorted set store: keeps up to CAPACITY distinct signed 32-bit values in
// ascending order in a memory with one write port and one registered read
// port, and answers one command word at a time (req_ready is low while a
// command is in progress). All timing is set by that read port feeding a single
// comparator: every stored entry touched takes a read state and a compare or
// write state. Every command takes its word in idle. An insert then reads and
// compares each entry (every entry below the new value, plus the first one
// that is not, if any), reads and writes each entry shifted up, then writes
// and reports; a rejected insert (duplicate or full) reports straight after
// the scan. A dump reads and reports each stored entry in turn, and a clear
// or an empty dump goes from idle straight to its report. The result register
// lets a new command word be taken while the final result still waits on
// rsp_ready; a stalled rsp side holds the sequencer only where it has a result to load.
module sorted_set_insert_top
    import ssi_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  ssi_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output ssi_rsp_t rsp
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

    ssi_state_t state_reg, state_next;

    logic        [CNT_W-1:0] idx_reg, idx_next;
    logic        [CNT_W-1:0] pos_reg, pos_next;
    logic        [CNT_W-1:0] occ_reg, occ_next;
    logic signed [31:0]      val_reg, val_next;
    status_t                 status_reg, status_next;

    logic     rsp_valid_reg, rsp_valid_next;
    ssi_rsp_t rsp_reg, rsp_next;

    logic signed [31:0] mem [CAPACITY];
    logic signed [31:0] rd_data_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic signed [31:0] wr_data;

    logic             slot_free;
    logic             less;
    logic             equal;
    logic             scan_end;
    logic             dump_end;
    logic [CNT_W-1:0] idx_dec;

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign less      = rd_data_reg < val_reg;
    assign equal     = rd_data_reg == val_reg;
    assign scan_end  = (idx_reg + ONE) == occ_reg;
    assign dump_end  = scan_end;
    assign idx_dec   = idx_reg - ONE;

    assign req_ready = state_reg == S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Read port address: shifts fetch the entry below the one being written
    always_comb
    begin
        if (state_reg == S_SHIFT_RD || state_reg == S_SHIFT_WR)
        begin
            rd_addr = idx_dec[ADDR_W-1:0];
        end
        else
        begin
            rd_addr = idx_reg[ADDR_W-1:0];
        end
    end

    // Store memory with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    priority case (req.cmd)
                        CMD_INSERT: state_next = (occ_reg == '0) ? S_WRITE : S_SCAN_RD;
                        CMD_DUMP:   state_next = (occ_reg == '0) ? S_RESULT : S_DUMP_RD;
                        CMD_CLEAR:  state_next = S_RESULT;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (less)
                begin
                    if (!scan_end)
                    begin
                        state_next = S_SCAN_RD;
                    end
                    else if (occ_reg == CAP_CNT)
                    begin
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
                else if (equal || occ_reg == CAP_CNT)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD:
            begin
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                state_next = (idx_dec == pos_reg) ? S_WRITE : S_SHIFT_RD;
            end
            S_WRITE:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DUMP_RD:
            begin
                state_next = S_DUMP_OUT;
            end
            S_DUMP_OUT:
            begin
                if (slot_free)
                begin
                    state_next = dump_end ? S_IDLE : S_DUMP_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and result control
    always_comb
    begin
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        occ_next       = occ_reg;
        val_next       = val_reg;
        status_next    = status_reg;
        wr_en          = 1'b0;
        wr_addr        = pos_reg[ADDR_W-1:0];
        wr_data        = val_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                // Latch the command word and start at entry zero
                if (req_valid)
                begin
                    val_next    = req.value;
                    idx_next    = '0;
                    pos_next    = '0;
                    status_next = ST_INSERTED;
                    if (req.cmd == CMD_CLEAR)
                    begin
                        occ_next    = '0;
                        status_next = ST_EMPTY;
                    end
                    else if (req.cmd == CMD_DUMP)
                    begin
                        status_next = ST_EMPTY;
                    end
                end
            end
            S_SCAN_CMP:
            begin
                // Advance past smaller entries, else settle the position
                if (less)
                begin
                    idx_next = idx_reg + ONE;
                    if (scan_end)
                    begin
                        pos_next    = occ_reg;
                        status_next = ST_INSERTED;
                        if (occ_reg == CAP_CNT)
                        begin
                            pos_next    = '0;
                            status_next = ST_FULL;
                        end
                    end
                end
                else if (equal)
                begin
                    pos_next    = idx_reg;
                    status_next = ST_DUP;
                end
                else if (occ_reg == CAP_CNT)
                begin
                    pos_next    = '0;
                    status_next = ST_FULL;
                end
                else
                begin
                    pos_next    = idx_reg;
                    idx_next    = occ_reg;
                    status_next = ST_INSERTED;
                end
            end
            S_SHIFT_WR:
            begin
                // Move one entry up a place
                wr_en    = 1'b1;
                wr_addr  = idx_reg[ADDR_W-1:0];
                wr_data  = rd_data_reg;
                idx_next = idx_dec;
            end
            S_WRITE:
            begin
                wr_en    = 1'b1;
                wr_addr  = pos_reg[ADDR_W-1:0];
                wr_data  = val_reg;
                occ_next = occ_reg + ONE;
            end
            S_RESULT:
            begin
                if (slot_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = status_reg;
                    rsp_next.position    = 5'(pos_reg);
                    rsp_next.entry_value = '0;
                    rsp_next.entry_count = 5'(occ_reg);
                    rsp_next.last        = 1'b1;
                end
            end
            S_DUMP_OUT:
            begin
                if (slot_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = ST_ENTRY;
                    rsp_next.position    = 5'(idx_reg);
                    rsp_next.entry_value = rd_data_reg;
                    rsp_next.entry_count = 5'(occ_reg);
                    rsp_next.last        = dump_end;
                    idx_next             = idx_reg + ONE;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

    // Occupancy stays within the store
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CAP_CNT)
        else $error("occupancy exceeds capacity");

    // A finished insert grows the store by one
    a_occ_grow: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WRITE |=> occ_reg == $past(occ_reg) + ONE)
        else $error("insert did not grow occupancy");

    // A clear empties the store
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req.cmd == CMD_CLEAR) |=> occ_reg == '0)
        else $error("clear left entries");

    // Only dump entries may be followed by more results
    a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.last) |-> rsp.status == ST_ENTRY)
        else $error("non-final result is not a dump entry");

    // An inserted result always reports a nonempty store
    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == ST_INSERTED) |-> rsp.entry_count != '0)
        else $error("insert reported empty store");

endmodule
